@@ rtl/core/stepper_ramp_mode_controller_assert.svh @@
// Assertion macros used by the stepper ramp controller core.
`ifndef STEPPER_RAMP_MODE_CONTROLLER_ASSERT_SVH
`define STEPPER_RAMP_MODE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SRMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRMC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/srmc_pkg.sv @@
// Shared types and constants for the stepper ramp mode controller.
package srmc_pkg;

    localparam int CMD_W   = 2;
    localparam int MODE_W  = 3;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 32;
    localparam int GROUP_W = 7;

    localparam int STEPS_PER_GROUP_DEF = 100;

    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_HOME = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd2;

    localparam logic [MODE_W-1:0] MODE_WAIT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HOME   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EXAM   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DECEL  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RETURN = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [MODE_W-1:0]  mode_value;
        logic [INDEX_W-1:0] index_value;
        logic               ramp_up;
    } req_t;

    typedef struct packed {
        logic               reload_write;
        logic [INDEX_W-1:0] table_index;
        logic               motor_stop;
        logic [MODE_W-1:0]  mode_now;
        logic [COUNT_W-1:0] travel_now;
    } res_t;

    typedef struct packed {
        logic [INDEX_W-1:0] free_max_index;
        logic [INDEX_W-1:0] exam_max_index;
        logic [INDEX_W-1:0] target_index;
        logic [COUNT_W-1:0] mark_position;
        logic [COUNT_W-1:0] zero_travel;
    } cfg_t;

endpackage

@@ rtl/core/srmc_ifs.sv @@
// Request and result channel interfaces.
interface srmc_req_if;
    logic                          valid;
    logic                          ready;
    logic [srmc_pkg::CMD_W-1:0]    command;
    logic [srmc_pkg::MODE_W-1:0]   mode_value;
    logic [srmc_pkg::INDEX_W-1:0]  index_value;
    logic                          ramp_up;

    modport source (output valid, command, mode_value, index_value, ramp_up, input ready);
    modport sink   (input valid, command, mode_value, index_value, ramp_up, output ready);
endinterface

interface srmc_res_if;
    logic                          valid;
    logic                          ready;
    logic                          reload_write;
    logic [srmc_pkg::INDEX_W-1:0]  table_index;
    logic                          motor_stop;
    logic [srmc_pkg::MODE_W-1:0]   mode_now;
    logic [srmc_pkg::COUNT_W-1:0]  travel_now;

    modport source (output valid, reload_write, table_index, motor_stop, mode_now,
                     travel_now, input ready);
    modport sink   (input valid, reload_write, table_index, motor_stop, mode_now,
                     travel_now, output ready);
endinterface

@@ rtl/core/srmc_cfg_regs.sv @@
// APB configuration registers.
module srmc_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output srmc_pkg::cfg_t       cfg
);
    import srmc_pkg::*;

    localparam logic [2:0] REG_FREE_MAX = 3'd0;
    localparam logic [2:0] REG_EXAM_MAX = 3'd1;
    localparam logic [2:0] REG_TARGET   = 3'd2;
    localparam logic [2:0] REG_MARK     = 3'd3;
    localparam logic [2:0] REG_ZERO     = 3'd4;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_FREE_MAX: cfg_next.free_max_index = pwdata[INDEX_W-1:0];
                REG_EXAM_MAX: cfg_next.exam_max_index = pwdata[INDEX_W-1:0];
                REG_TARGET:   cfg_next.target_index   = pwdata[INDEX_W-1:0];
                REG_MARK:     cfg_next.mark_position  = pwdata;
                REG_ZERO:     cfg_next.zero_travel    = pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_FREE_MAX: prdata = {24'd0, cfg_reg.free_max_index};
            REG_EXAM_MAX: prdata = {24'd0, cfg_reg.exam_max_index};
            REG_TARGET:   prdata = {24'd0, cfg_reg.target_index};
            REG_MARK:     prdata = cfg_reg.mark_position;
            REG_ZERO:     prdata = cfg_reg.zero_travel;
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/srmc_core.sv @@
// Ramp state registers and the per-request step logic.
module srmc_core #(
    parameter int STEPS_PER_GROUP = srmc_pkg::STEPS_PER_GROUP_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  srmc_pkg::req_t  req,
    input  srmc_pkg::cfg_t  cfg,
    output srmc_pkg::res_t  res
);
    import srmc_pkg::*;

    `include "stepper_ramp_mode_controller_assert.svh"

    localparam logic [GROUP_W-1:0] GROUP_END = GROUP_W'(STEPS_PER_GROUP);

    logic [MODE_W-1:0]  mode_reg,          mode_next;
    logic [GROUP_W-1:0] group_count_reg,   group_count_next;
    logic [COUNT_W-1:0] travel_count_reg,  travel_count_next;
    logic [COUNT_W-1:0] return_travel_reg, return_travel_next;
    logic [INDEX_W-1:0] speed_index_reg,   speed_index_next;

    logic [GROUP_W-1:0] gc_inc;
    logic [COUNT_W-1:0] tr_inc;
    logic               group_end;
    logic               go_up;
    logic               go_down;
    logic               stop;

    always_comb
    begin
        gc_inc             = group_count_reg + 1'b1;
        tr_inc             = travel_count_reg + 1'b1;
        group_end          = gc_inc >= GROUP_END;
        mode_next          = mode_reg;
        group_count_next   = group_count_reg;
        travel_count_next  = travel_count_reg;
        return_travel_next = return_travel_reg;
        speed_index_next   = speed_index_reg;
        go_up              = 1'b0;
        go_down            = 1'b0;
        stop               = 1'b0;

        case (req.command)
            CMD_TICK:
            begin
                group_count_next  = gc_inc;
                travel_count_next = tr_inc;
                if (group_end && (mode_reg inside {[MODE_FREE:MODE_RETURN]}))
                begin
                    group_count_next = '0;
                end
                case (mode_reg)
                    MODE_FREE:
                    begin
                        if (group_end && speed_index_reg <= cfg.free_max_index)
                        begin
                            go_up = 1'b1;
                        end
                    end
                    MODE_HOME, MODE_RETURN:
                    begin
                        if (group_end)
                        begin
                            if (tr_inc < cfg.mark_position)
                            begin
                                go_up = speed_index_reg < cfg.target_index;
                            end
                            else
                            begin
                                go_down = speed_index_reg != '0;
                            end
                        end
                        if (mode_reg == MODE_HOME)
                        begin
                            if (tr_inc >= cfg.zero_travel)
                            begin
                                stop              = 1'b1;
                                travel_count_next = '0;
                                group_count_next  = '0;
                            end
                        end
                        else if (tr_inc >= return_travel_reg)
                        begin
                            mode_next          = MODE_WAIT;
                            stop               = 1'b1;
                            travel_count_next  = '0;
                            return_travel_next = '0;
                            group_count_next   = '0;
                        end
                    end
                    MODE_EXAM:
                    begin
                        if (group_end)
                        begin
                            if (req.ramp_up)
                            begin
                                go_up = speed_index_reg < cfg.exam_max_index;
                            end
                            else
                            begin
                                go_down = speed_index_reg != '0;
                            end
                        end
                    end
                    MODE_DECEL:
                    begin
                        if (group_end)
                        begin
                            if (speed_index_reg != '0)
                            begin
                                go_down = 1'b1;
                            end
                            else
                            begin
                                stop               = 1'b1;
                                return_travel_next = tr_inc;
                                mode_next          = MODE_RETURN;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            CMD_HOME:
            begin
                stop = mode_reg != MODE_HOME;
                if (mode_reg == MODE_FREE)
                begin
                    mode_next         = MODE_HOME;
                    travel_count_next = '0;
                end
            end
            CMD_LOAD:
            begin
                mode_next        = (req.mode_value <= MODE_RETURN) ? req.mode_value : MODE_WAIT;
                speed_index_next = req.index_value;
            end
            default: ;
        endcase

        // saturate upward steps at the top of the table
        if (go_up && speed_index_reg != '1)
        begin
            speed_index_next = speed_index_reg + 1'b1;
        end
        else if (go_down)
        begin
            speed_index_next = speed_index_reg - 1'b1;
        end

        res.reload_write = go_up || go_down;
        res.table_index  = (go_up || go_down) ? speed_index_reg : '0;
        res.motor_stop   = stop;
        res.mode_now     = mode_next;
        res.travel_now   = travel_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_WAIT;
            group_count_reg   <= '0;
            travel_count_reg  <= '0;
            return_travel_reg <= '0;
            speed_index_reg   <= '0;
        end
        else if (step_en)
        begin
            mode_reg          <= mode_next;
            group_count_reg   <= group_count_next;
            travel_count_reg  <= travel_count_next;
            return_travel_reg <= return_travel_next;
            speed_index_reg   <= speed_index_next;
        end
    end

    `SRMC_ASSERT_NXT(a_reload_moves_index, clk, rst_n,
        step_en && res.reload_write && res.table_index != '1,
        speed_index_reg != $past(speed_index_reg), "reload without index move")
    `SRMC_ASSERT_NXT(a_return_stop_clears, clk, rst_n,
        step_en && req.command == CMD_TICK && mode_reg == MODE_RETURN && res.motor_stop,
        mode_reg == MODE_WAIT && travel_count_reg == '0 && return_travel_reg == '0,
        "return stop did not clear")
    `SRMC_ASSERT_NXT(a_load_keeps_counts, clk, rst_n,
        step_en && req.command == CMD_LOAD,
        $stable(travel_count_reg) && $stable(group_count_reg), "load moved counters")
    `SRMC_ASSERT_IMP(a_idle_holds_state, clk, rst_n,
        !step_en, !res.reload_write || res.table_index == speed_index_reg,
        "table index mismatch")

endmodule

@@ rtl/core/stepper_ramp_mode_controller.sv @@
// Stepper ramp mode controller top level: request register, step core, result register.
//
// Channels: request (command, mode_value, index_value, ramp_up) in, result
// (reload_write, table_index, motor_stop, mode_now, travel_now) out, each a
// valid/ready pair; a request moves at an edge with valid and ready high.
// Every request yields exactly one result, in order.
// Configuration: APB port, registers at byte addresses 0,4,8,12,16;
// pready is tied high; reads return the stored value.
// Path: a taken request is held in the request register, and its result
// is then written to the result register, from which it leaves.
// Throughput: one request per cycle while result.ready is high; the step
// logic is combinational between the two registers, and the ramp state
// updates at the same edge that writes the result register.
// Stall: while result.ready is low the held result stays put, one more
// request may wait in the request register, then request.ready drops.
// Reset: rst_n clears mode to wait, all counters, the speed index, the
// configuration registers and both valid flags.
module stepper_ramp_mode_controller #(
    parameter int STEPS_PER_GROUP = srmc_pkg::STEPS_PER_GROUP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    srmc_req_if.sink    request,
    srmc_res_if.source  result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import srmc_pkg::*;

    cfg_t cfg;
    req_t req_reg;
    logic req_valid_reg;
    res_t res_reg;
    logic res_valid_reg;
    res_t core_res;
    logic advance;
    logic step_en;

    assign advance       = !res_valid_reg || result.ready;
    assign request.ready = !req_valid_reg || advance;
    assign step_en       = req_valid_reg && advance;

    srmc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srmc_core #(
        .STEPS_PER_GROUP (STEPS_PER_GROUP)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .req     (req_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (request.ready)
            begin
                req_valid_reg <= request.valid;
            end
            if (advance)
            begin
                res_valid_reg <= req_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.ready && request.valid)
        begin
            req_reg.command     <= request.command;
            req_reg.mode_value  <= request.mode_value;
            req_reg.index_value <= request.index_value;
            req_reg.ramp_up     <= request.ramp_up;
        end
        if (step_en)
        begin
            res_reg <= core_res;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.reload_write = res_reg.reload_write;
    assign result.table_index  = res_reg.table_index;
    assign result.motor_stop   = res_reg.motor_stop;
    assign result.mode_now     = res_reg.mode_now;
    assign result.travel_now   = res_reg.travel_now;

endmodule
